// ----- sv/owm_pkg.sv -----
// Shared types, codes and constants of the one-wire bus master.
package owm_pkg;

  localparam int CNT_W    = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 8;

  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_WBYTE = 3'd1;
  localparam logic [2:0] OP_RBYTE = 3'd2;
  localparam logic [2:0] OP_WBIT  = 3'd3;
  localparam logic [2:0] OP_RBIT  = 3'd4;

  localparam logic [2:0] REG_RST_LOW  = 3'd0;
  localparam logic [2:0] REG_PRES_WT  = 3'd1;
  localparam logic [2:0] REG_RST_REC  = 3'd2;
  localparam logic [2:0] REG_WR_LOW   = 3'd3;
  localparam logic [2:0] REG_WR_HOLD  = 3'd4;
  localparam logic [2:0] REG_RD_LOW   = 3'd5;
  localparam logic [2:0] REG_RD_SMP   = 3'd6;
  localparam logic [2:0] REG_RD_REC   = 3'd7;

  localparam logic [NUM_REGS-1:0][CNT_W-1:0] REG_DEFAULTS = {
    16'd45, 16'd10, 16'd5, 16'd50, 16'd10, 16'd500, 16'd80, 16'd500
  };

  typedef logic [NUM_REGS-1:0][CNT_W-1:0] timing_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } result_t;

endpackage

// ----- sv/owm_if.sv -----
// Channel interfaces: tick input, per-tick result and register write.
interface owm_in_if;
  import owm_pkg::*;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       line_level;
  modport source (output valid, cmd_valid, op, tx_byte, line_level, input ready);
  modport sink   (input valid, cmd_valid, op, tx_byte, line_level, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;
  modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                  output ready);
endinterface

interface owm_cfg_if;
  import owm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CNT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/owm_cfg_regs.sv -----
// Timing register file written through the configuration channel.
module owm_cfg_regs
  import owm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  owm_cfg_if.sink cfg,
  output timing_t timing
);

  timing_t regs_r;

  assign cfg.ready = 1'b1;
  assign timing    = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REG_DEFAULTS;
    end else if (cfg.valid && cfg.ready && (cfg.index < IDX_W'(NUM_REGS))) begin
      regs_r[cfg.index[2:0]] <= cfg.data;
    end
  end

endmodule

// ----- sv/owm_fsm.sv -----
// Bus sequencer: phase, tick counter, bit index and shift data, one tick per fire.
module owm_fsm
  import owm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  timing_t timing,
  output result_t res
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REC  = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HOLD  = 4'd5;
  localparam logic [3:0] PH_WR_GAP   = 4'd6;
  localparam logic [3:0] PH_RD_LOW   = 4'd7;
  localparam logic [3:0] PH_RD_WAIT  = 4'd8;
  localparam logic [3:0] PH_RD_REC   = 4'd9;

  logic [3:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             pres_r, pres_nxt;

  logic [3:0]       ph;
  logic [2:0]       sel;
  logic [CNT_W-1:0] len;
  logic [CNT_W:0]   cnt_inc;
  logic             end_hit;
  logic             slot_over;
  logic             is_byte;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    op_nxt    = op_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    res       = '0;
    slot_over = 1'b0;
    sel       = REG_RST_LOW;

    if (phase_r == PH_IDLE && item.cmd_valid && item.op <= OP_RBIT) begin
      op_nxt   = item.op;
      tick_nxt = '0;
      bit_nxt  = '0;
      if (item.op == OP_RESET) begin
        phase_nxt = PH_RST_LOW;
      end else if (item.op == OP_WBYTE || item.op == OP_WBIT) begin
        shift_nxt = item.tx_byte;
        phase_nxt = PH_WR_LOW;
      end else begin
        shift_nxt = '0;
        phase_nxt = PH_RD_LOW;
      end
    end
    ph = phase_nxt;

    unique case (ph)
      PH_RST_LOW:  sel = REG_RST_LOW;
      PH_RST_WAIT: sel = REG_PRES_WT;
      PH_RST_REC:  sel = REG_RST_REC;
      PH_WR_LOW:   sel = REG_WR_LOW;
      PH_WR_HOLD:  sel = REG_WR_HOLD;
      PH_RD_LOW:   sel = REG_RD_LOW;
      PH_RD_WAIT:  sel = REG_RD_SMP;
      PH_RD_REC:   sel = REG_RD_REC;
      default:     sel = REG_RST_LOW;
    endcase
    len     = (timing[sel] == '0) ? CNT_W'(1) : timing[sel];
    cnt_inc = {1'b0, tick_nxt} + (CNT_W+1)'(1);
    end_hit = cnt_inc >= {1'b0, len};

    if (ph != PH_IDLE) begin
      res.busy_res = 1'b1;
      if (ph != PH_WR_GAP) begin
        tick_nxt = end_hit ? '0 : cnt_inc[CNT_W-1:0];
      end
      unique case (ph)
        PH_RST_LOW: begin
          res.drive_low = 1'b1;
          if (end_hit) phase_nxt = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (end_hit) begin
            pres_nxt  = ~item.line_level;
            phase_nxt = PH_RST_REC;
          end
        end
        PH_RST_REC: begin
          if (end_hit) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end
        end
        PH_WR_LOW: begin
          res.drive_low = 1'b1;
          if (end_hit) phase_nxt = PH_WR_HOLD;
        end
        PH_WR_HOLD: begin
          res.drive_low = ~shift_nxt[0];
          if (end_hit) phase_nxt = PH_WR_GAP;
        end
        PH_WR_GAP: begin
          tick_nxt  = '0;
          shift_nxt = {1'b0, shift_nxt[7:1]};
          slot_over = 1'b1;
        end
        PH_RD_LOW: begin
          res.drive_low = 1'b1;
          if (end_hit) phase_nxt = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          if (end_hit) begin
            if (op_nxt == OP_RBYTE) shift_nxt = {item.line_level, shift_nxt[7:1]};
            else                    shift_nxt = {7'd0, item.line_level};
            phase_nxt = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          if (end_hit) slot_over = 1'b1;
        end
        default: begin
          phase_nxt    = PH_IDLE;
          tick_nxt     = '0;
          res.busy_res = 1'b0;
        end
      endcase

      is_byte = (op_nxt == OP_WBYTE) || (op_nxt == OP_RBYTE);
      if (slot_over) begin
        if (is_byte && bit_nxt != 3'd7) begin
          bit_nxt   = bit_nxt + 3'd1;
          phase_nxt = (op_nxt == OP_WBYTE) ? PH_WR_LOW : PH_RD_LOW;
        end else begin
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          if (op_nxt == OP_RBYTE || op_nxt == OP_RBIT) res.rx_byte = shift_nxt;
        end
      end
    end else begin
      is_byte = 1'b0;
    end
    res.presence = pres_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      op_r    <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      op_r    <= op_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

// ----- sv/one_wire_bus_master_core.sv -----
// One-wire bus master top level: input register, sequencer, result register.
// Each tick passes through the input register and then the result register.
// Throughput: one tick per clock cycle; a stalled result register holds the input side.
// Phase lengths are counted in ticks from the eight timing registers.
// Reset (rst_n low, synchronous): sequencer idle, pipeline empty, timing registers
// return to their defaults.
module one_wire_bus_master_core
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  owm_in_if.sink    in_ch,
  owm_out_if.source out_ch,
  owm_cfg_if.sink   cfg_ch
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  timing_t timing;
  logic    advance;
  logic    fire;

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;

  owm_cfg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .timing (timing)
  );

  owm_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .timing (timing),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance)     out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{cmd_valid:  in_ch.cmd_valid,
                     op:         in_ch.op,
                     tx_byte:    in_ch.tx_byte,
                     line_level: in_ch.line_level};
    end
    if (fire) out_res_r <= res;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_low = out_res_r.drive_low;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.done_res  = out_res_r.done_res;
  assign out_ch.presence  = out_res_r.presence;
  assign out_ch.rx_byte   = out_res_r.rx_byte;

endmodule

// ----- sim/owm_bus_checker.sv -----
// Checker for the one-wire bus master: tracks the bus sequencer per tick and compares every result.
module owm_bus_checker
  import owm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  owm_in_if    in_ch,
  owm_out_if   out_ch,
  owm_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   completed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_LOW, PH_WR_HOLD, PH_WR_GAP,
    PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
  } bus_phase_e;

  timing_t     timing;
  bus_phase_e  seq;
  logic [15:0] ticks;
  logic [2:0]  bit_no;
  logic [2:0]  cur_op;
  logic [7:0]  shreg;
  logic        pres;
  result_t     tick_results_due[$];
  int          n_bad;
  int          n_done;

  // zero length counts as one tick
  function automatic int unsigned span(logic [2:0] r);
    return (timing[r] == '0) ? 1 : int'(timing[r]);
  endfunction

  function automatic bit phase_over(int unsigned len);
    if ({16'd0, ticks} + 32'd1 >= len) begin
      ticks = '0;
      return 1'b1;
    end
    ticks = ticks + 16'd1;
    return 1'b0;
  endfunction

  function automatic result_t next_tick_result(item_t it);
    result_t r;
    logic    slot_over;
    r = '0;
    slot_over = 1'b0;
    if (seq == PH_IDLE && it.cmd_valid && it.op <= OP_RBIT) begin
      cur_op = it.op;
      ticks = '0;
      bit_no = '0;
      if (it.op == OP_RESET) begin
        seq = PH_RST_LOW;
      end else if (it.op == OP_WBYTE || it.op == OP_WBIT) begin
        shreg = it.tx_byte;
        seq = PH_WR_LOW;
      end else begin
        shreg = '0;
        seq = PH_RD_LOW;
      end
    end
    if (seq != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (seq)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          if (phase_over(span(REG_RST_LOW))) seq = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (phase_over(span(REG_PRES_WT))) begin
            pres = ~it.line_level;
            seq = PH_RST_REC;
          end
        end
        PH_RST_REC: begin
          if (phase_over(span(REG_RST_REC))) begin
            seq = PH_IDLE;
            r.done_res = 1'b1;
          end
        end
        PH_WR_LOW: begin
          r.drive_low = 1'b1;
          if (phase_over(span(REG_WR_LOW))) seq = PH_WR_HOLD;
        end
        PH_WR_HOLD: begin
          r.drive_low = ~shreg[0];
          if (phase_over(span(REG_WR_HOLD))) seq = PH_WR_GAP;
        end
        PH_WR_GAP: begin
          ticks = '0;
          shreg = shreg >> 1;
          slot_over = 1'b1;
        end
        PH_RD_LOW: begin
          r.drive_low = 1'b1;
          if (phase_over(span(REG_RD_LOW))) seq = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          if (phase_over(span(REG_RD_SMP))) begin
            shreg = (cur_op == OP_RBYTE) ? {it.line_level, shreg[7:1]} : {7'd0, it.line_level};
            seq = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          if (phase_over(span(REG_RD_REC))) slot_over = 1'b1;
        end
        default: ;
      endcase
      if (slot_over) begin
        if ((cur_op == OP_WBYTE || cur_op == OP_RBYTE) && bit_no != 3'd7) begin
          bit_no = bit_no + 3'd1;
          seq = (cur_op == OP_WBYTE) ? PH_WR_LOW : PH_RD_LOW;
        end else begin
          seq = PH_IDLE;
          r.done_res = 1'b1;
          if (cur_op == OP_RBYTE || cur_op == OP_RBIT) r.rx_byte = shreg;
        end
      end
    end
    r.presence = pres;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      timing[REG_RST_LOW] = 16'd500;
      timing[REG_PRES_WT] = 16'd80;
      timing[REG_RST_REC] = 16'd500;
      timing[REG_WR_LOW]  = 16'd10;
      timing[REG_WR_HOLD] = 16'd50;
      timing[REG_RD_LOW]  = 16'd5;
      timing[REG_RD_SMP]  = 16'd10;
      timing[REG_RD_REC]  = 16'd45;
      seq = PH_IDLE;
      ticks = '0;
      bit_no = '0;
      cur_op = '0;
      shreg = '0;
      pres = 1'b0;
      tick_results_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.drive_low, out_ch.busy_res, out_ch.done_res, out_ch.presence,
               out_ch.rx_byte};
        if (tick_results_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result with nothing expected: drive=%b busy=%b done=%b pres=%b rx=%h",
                     got.drive_low, got.busy_res, got.done_res, got.presence, got.rx_byte);
        end else begin
          want = tick_results_due.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch: expected drive=%b busy=%b done=%b pres=%b rx=%h, ",
                        "got drive=%b busy=%b done=%b pres=%b rx=%h"},
                       want.drive_low, want.busy_res, want.done_res, want.presence,
                       want.rx_byte, got.drive_low, got.busy_res, got.done_res,
                       got.presence, got.rx_byte);
          end
          if (want.done_res) n_done++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < NUM_REGS)
        timing[cfg_ch.index[2:0]] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        tick_results_due.push_back(next_tick_result({in_ch.cmd_valid, in_ch.op,
                                                     in_ch.tx_byte, in_ch.line_level}));
    end
    mismatches  <= n_bad;
    outstanding <= tick_results_due.size();
    completed   <= n_done;
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top for the one-wire bus master: clock, reset, tick and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import owm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;

  logic clk;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;
  int   hold_asked;
  int   hold_taken;
  int   hold_left;
  int   idle_cycles;
  int   ticks_sent;
  int   reg_writes;
  int   setups;
  int   mismatches;
  int   outstanding;
  int   completed;

  owm_in_if  in_ch();
  owm_out_if out_ch();
  owm_cfg_if cfg_ch();

  one_wire_bus_master_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  owm_bus_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .completed  (completed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                           input logic lvl);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= cv;
    in_ch.op         <= op;
    in_ch.tx_byte    <= tx;
    in_ch.line_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic quiet_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
  endtask

  task automatic random_ticks(input int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_tick($urandom_range(0, 4) == 0, op, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
  endtask

  task automatic program_timing(input timing_t t);
    for (int r = 0; r < NUM_REGS; r++) write_reg(IDX_W'(r), t[r]);
    cfg_ch.valid <= 1'b0;
    setups++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    timing_t t;
    in_ch.valid      = 1'b0;
    in_ch.cmd_valid  = 1'b0;
    in_ch.op         = OP_RESET;
    in_ch.tx_byte    = '0;
    in_ch.line_level = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    gap_pct          = 0;
    stall_pct        = 0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // power-on timing: one write slot, one read slot, then a reset cut short
    send_tick(1'b1, OP_WBIT, 8'($urandom), 1'b1);
    quiet_ticks(61);
    send_tick(1'b1, OP_RBIT, 8'($urandom), 1'b1);
    quiet_ticks(61);
    send_tick(1'b1, OP_RESET, 8'h00, 1'b1);
    quiet_ticks(19);
    drain();
    write_reg(REG_RST_LOW, 16'd3);
    write_reg(REG_PRES_WT, 16'd2);
    write_reg(REG_RST_REC, 16'd2);
    cfg_ch.valid <= 1'b0;
    quiet_ticks(8);
    drain();
    write_reg(REG_WR_HOLD, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    send_tick(1'b1, OP_WBIT, 8'h00, 1'b0);
    quiet_ticks(30);
    drain();
    write_reg(REG_WR_HOLD, 16'd1);
    cfg_ch.valid <= 1'b0;
    quiet_ticks(4);
    drain();

    // all lengths zero (one tick each); out-of-range indexes must not land
    write_reg(8'd8, 16'hFFFF);
    write_reg(8'hFF, 16'hFFFF);
    program_timing('0);
    send_tick(1'b1, OP_RESET, 8'h00, 1'b1);
    send_tick(1'b0, OP_RESET, 8'h00, 1'b0);
    send_tick(1'b0, OP_RESET, 8'h00, 1'b1);
    send_tick(1'b1, OP_RESET, 8'hFF, 1'b0);
    send_tick(1'b0, OP_RESET, 8'hFF, 1'b1);
    send_tick(1'b0, OP_RESET, 8'hFF, 1'b0);
    send_tick(1'b1, OP_WBIT, 8'hFF, 1'b1);
    send_tick(1'b0, OP_WBIT, 8'hFF, 1'b1);
    send_tick(1'b0, OP_WBIT, 8'hFF, 1'b1);
    send_tick(1'b1, OP_WBIT, 8'h00, 1'b0);
    send_tick(1'b1, OP_RBYTE, 8'hAA, 1'b1);
    send_tick(1'b0, OP_WBIT, 8'h00, 1'b0);
    send_tick(1'b1, OP_RBIT, 8'h55, 1'b0);
    send_tick(1'b0, OP_RBIT, 8'h00, 1'b1);
    send_tick(1'b0, OP_RBIT, 8'h00, 1'b0);
    send_tick(1'b1, OP_RBIT, 8'h00, 1'b1);
    send_tick(1'b0, OP_RBIT, 8'h00, 1'b0);
    send_tick(1'b0, OP_RBIT, 8'h00, 1'b1);
    send_tick(1'b1, 3'd5, 8'h0F, 1'b1);
    send_tick(1'b1, 3'd7, 8'hF0, 1'b0);
    send_tick(1'b0, OP_WBYTE, 8'hFF, 1'b1);

    for (int p = 0; p < 12; p++) begin
      drain();
      for (int r = 0; r < NUM_REGS; r++)
        t[r] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 16))
                                            : 16'($urandom_range(0, 3));
      program_timing(t);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 59;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 59;
        end
        default: begin
          gap_pct = 28;
          stall_pct <= 28;
        end
      endcase
      if (p == 4) hold_asked <= hold_asked + 1;
      random_ticks(120);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks, %0d register writes, %0d timing setups, %0d commands completed",
             ticks_sent, reg_writes, setups, completed);
    $display("idling: none, sender, receiver and both, plus one long receiver hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
